// File: hw/rtl/deq_pkg.sv
`default_nettype none

package deq_pkg;

  localparam int WORD_W = 32;

  // operation codes on mode_i
  localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [2:0] MODE_POP_BACK   = 3'd3;
  localparam logic [2:0] MODE_REMOVE     = 3'd4;
  localparam logic [2:0] MODE_FIND       = 3'd5;
  localparam logic [2:0] MODE_CLEAR      = 3'd6;

  // result codes on status_o
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

endpackage

`default_nettype wire

// File: hw/rtl/deq_ring_add.sv
`default_nettype none

// Ring slot adder: (a + b) mod DEPTH, both operands below DEPTH.
module deq_ring_add #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  wire logic [IW-1:0] a_i,
  input  wire logic [IW-1:0] b_i,
  output logic      [IW-1:0] sum_o
);

  localparam logic [IW:0] DepthW = (IW+1)'(DEPTH);

  logic [IW:0] raw;

  always_comb begin
    raw = {1'b0, a_i} + {1'b0, b_i};
    if (raw >= DepthW) begin
      raw = raw - DepthW;
    end
    sum_o = raw[IW-1:0];
  end

endmodule

`default_nettype wire

// File: hw/rtl/deq_ram.sv
`default_nettype none

// Entry store: one write port, one read port, registered read data.
module deq_ram import deq_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [WORD_W-1:0] wdata_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: hw/rtl/bounded_deque_with_search_unit.sv
`default_nettype none

// Bounded deque of signed 32-bit words with find and remove-by-value.
//
// Command channel: drive mode_i/value_i and raise start_i; the word is taken
// on a rising edge where start_i is high and busy_o is low.
// Result channel: done_o is high for exactly one cycle with status_o,
// found_o and entry_count_o (entries held after the operation). The
// receiver cannot stall; each result must be taken in its cycle.
//
// Timing: push, pop, clear and the spare code finish in the cycle they
// are taken; the result shows in the next cycle and busy_o stays low, so
// such commands may follow each other every cycle. Find scans from the
// front one entry per cycle, with busy_o high until a match or the last
// entry is checked; the result shows in the cycle after. Remove then moves
// each trailing entry up one place before its result shows. The pace is
// set by the single read port of the entry store and the one ring-address
// adder that steps through the slots.
//
// Reset clears count and front pointer; store contents are not cleared and
// are never used before being written.
module bounded_deque_with_search_unit import deq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [2:0]         mode_i,
  input  wire logic signed [31:0] value_i,
  output logic                    done_o,
  output logic      [1:0]         status_o,
  output logic                    found_o,
  output logic      [4:0]         entry_count_o
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapW = CW'(CAPACITY);

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [IW-1:0]     front_q, front_d;
  logic [CW-1:0]     count_q, count_d;
  logic [IW-1:0]     slot_q, slot_d;         // slot of entry at pos_q
  logic [IW-1:0]     nxt_slot_q, nxt_slot_d; // slot of entry at pos_q+1
  logic [CW-1:0]     pos_q, pos_d;
  logic [WORD_W-1:0] value_q, value_d;
  logic              rm_q, rm_d;
  logic              done_q, done_d;
  logic [1:0]        status_q, status_d;
  logic              found_q, found_d;

  // shared ring adder
  logic [IW-1:0] add_a, add_b, add_sum;

  // store ports
  logic              we;
  logic [IW-1:0]     waddr, raddr;
  logic [WORD_W-1:0] wdata, rd_data;

  logic          last_scan;   // pos_q is the last entry
  logic          last_shift;  // pos_q+1 is the last entry
  logic [31:0]   cnt_ext;

  deq_ring_add #(.DEPTH(CAPACITY), .IW(IW)) u_add (
    .a_i  (add_a),
    .b_i  (add_b),
    .sum_o(add_sum)
  );

  deq_ram #(.DEPTH(CAPACITY), .AW(IW)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rd_data)
  );

  assign last_scan  = ({1'b0, pos_q} + (CW+1)'(1)) == {1'b0, count_q};
  assign last_shift = ({1'b0, pos_q} + (CW+1)'(2)) == {1'b0, count_q};

  always_comb begin
    state_d    = state_q;
    front_d    = front_q;
    count_d    = count_q;
    slot_d     = slot_q;
    nxt_slot_d = nxt_slot_q;
    pos_d      = pos_q;
    value_d    = value_q;
    rm_d       = rm_q;
    done_d     = 1'b0;
    status_d   = status_q;
    found_d    = found_q;
    add_a      = nxt_slot_q;
    add_b      = IW'(1);
    we         = 1'b0;
    waddr      = add_sum;
    wdata      = value_i;
    raddr      = nxt_slot_q;

    case (state_q)
      ST_IDLE: begin
        add_a = front_q;
        raddr = front_q;
        if (start_i) begin
          done_d   = 1'b1;
          status_d = STATUS_OK;
          found_d  = 1'b0;
          case (mode_i)
            MODE_PUSH_FRONT: begin
              add_b = IW'(CAPACITY - 1);
              if (count_q >= CapW) begin
                status_d = STATUS_FULL;
              end else begin
                we      = 1'b1;
                front_d = add_sum;
                count_d = count_q + CW'(1);
              end
            end
            MODE_PUSH_BACK: begin
              add_b = count_q[IW-1:0];
              if (count_q >= CapW) begin
                status_d = STATUS_FULL;
              end else begin
                we      = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            MODE_POP_FRONT: begin
              if (count_q == '0) begin
                status_d = STATUS_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
                front_d = (count_q == CW'(1)) ? '0 : add_sum;
              end
            end
            MODE_POP_BACK: begin
              if (count_q == '0) begin
                status_d = STATUS_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
                if (count_q == CW'(1)) begin
                  front_d = '0;
                end
              end
            end
            MODE_REMOVE, MODE_FIND: begin
              if (count_q == '0) begin
                status_d = STATUS_EMPTY;
              end else begin
                // first read of the front slot goes out on this edge
                done_d     = 1'b0;
                state_d    = ST_SCAN;
                slot_d     = front_q;
                nxt_slot_d = add_sum;
                pos_d      = '0;
                value_d    = value_i;
                rm_d       = (mode_i == MODE_REMOVE);
              end
            end
            MODE_CLEAR: begin
              count_d = '0;
              front_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        // rd_data holds the entry at pos_q; the next read is nxt_slot_q
        if (rd_data == value_q) begin
          if (rm_q && !last_scan) begin
            state_d = ST_SHIFT;
          end else begin
            state_d  = ST_IDLE;
            done_d   = 1'b1;
            status_d = STATUS_OK;
            found_d  = 1'b1;
            if (rm_q) begin
              count_d = count_q - CW'(1);
              if (count_q == CW'(1)) begin
                front_d = '0;
              end
            end
          end
        end else if (last_scan) begin
          state_d  = ST_IDLE;
          done_d   = 1'b1;
          status_d = STATUS_EMPTY;
          found_d  = 1'b0;
        end else begin
          slot_d     = nxt_slot_q;
          nxt_slot_d = add_sum;
          pos_d      = pos_q + CW'(1);
        end
      end

      ST_SHIFT: begin
        // rd_data holds entry pos_q+1: move it up into slot_q
        raddr = add_sum;
        we    = 1'b1;
        waddr = slot_q;
        wdata = rd_data;
        if (last_shift) begin
          state_d  = ST_IDLE;
          done_d   = 1'b1;
          status_d = STATUS_OK;
          found_d  = 1'b1;
          count_d  = count_q - CW'(1);
        end else begin
          slot_d     = nxt_slot_q;
          nxt_slot_d = add_sum;
          pos_d      = pos_q + CW'(1);
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      front_q  <= '0;
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= STATUS_OK;
      found_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      front_q  <= front_d;
      count_q  <= count_d;
      done_q   <= done_d;
      status_q <= status_d;
      found_q  <= found_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    slot_q     <= slot_d;
    nxt_slot_q <= nxt_slot_d;
    pos_q      <= pos_d;
    value_q    <= value_d;
    rm_q       <= rm_d;
  end

  assign cnt_ext       = 32'(count_q);
  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_o       = found_q;
  assign entry_count_o = cnt_ext[4:0];

`ifndef SYNTH
  // a result always lands in a cycle where a new command may be taken
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapW)
    else $error("entry count above capacity");

  a_empty_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (front_q == '0))
    else $error("front pointer not home on empty store");

  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && count_q == CapW &&
     (mode_i == MODE_PUSH_FRONT || mode_i == MODE_PUSH_BACK))
    |=> (done_o && status_o == STATUS_FULL && $stable(count_q)))
    else $error("push into full store not dropped");
`endif

endmodule

`default_nettype wire

// File: test/tb_bounded_deque_with_search_unit.sv
module tb_bounded_deque_with_search_unit;
  import deq_pkg::*;

  localparam int DEPTH      = 16;
  localparam int RAND_WORDS = 1150;
  localparam int SETTLE_CYC = 4 * DEPTH;     // longer than the worst remove
  localparam int CYCLE_CAP  = 400000;        // well above the slowest legal run
  localparam logic [2:0] MODE_SPARE = 3'd7;  // unused code, must act as a no-op

  // one result word as seen on status_o/found_o/entry_count_o
  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [4:0] count;
  } result_t;

  // one row of the directed table; has_exp marks rows whose result is typed in
  typedef struct {
    logic [2:0]  mode;
    logic [31:0] value;
    logic        has_exp;
    result_t     exp;
  } stim_row_t;

  // DUT ports
  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [2:0]  mode_i;
  logic [31:0] value_i;
  logic        done_o;
  logic [1:0]  status_o;
  logic        found_o;
  logic [4:0]  entry_count_o;

  bounded_deque_with_search_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .mode_i        (mode_i),
    .value_i       (value_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .found_o       (found_o),
    .entry_count_o (entry_count_o)
  );

  // 20-unit clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow deque: ring of DEPTH words, head slot and fill level, kept in step
  // with every word the DUT takes.
  // ---------------------------------------------------------------------------
  logic [31:0] ring_q [DEPTH];
  logic [3:0]  head_q;
  logic [4:0]  fill_q;

  result_t   pending_results [$];   // predicted results, oldest first
  stim_row_t dir_rows [$];
  int        err_count;
  int        cycle_cnt;
  logic      quiet;                 // no idle gaps while set

  // typed expectation that travels with the word on the bus
  logic      row_has_exp;
  result_t   row_exp;

  // Apply one command to the shadow deque and return the result it gives.
  function automatic result_t deque_apply(logic [2:0] op, logic [31:0] v);
    result_t    r;
    int         pos;
    int         k;
    logic [3:0] slot;
    logic [3:0] next_slot;
    r   = '0;
    pos = DEPTH;
    case (op)
      MODE_PUSH_FRONT: begin
        if (fill_q == 5'(DEPTH)) begin
          r.status = STATUS_FULL;
        end else begin
          head_q         = head_q - 4'd1;
          ring_q[head_q] = v;
          fill_q         = fill_q + 5'd1;
        end
      end
      MODE_PUSH_BACK: begin
        if (fill_q == 5'(DEPTH)) begin
          r.status = STATUS_FULL;
        end else begin
          slot         = head_q + fill_q[3:0];
          ring_q[slot] = v;
          fill_q       = fill_q + 5'd1;
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        if (fill_q == 5'd0) begin
          r.status = STATUS_EMPTY;
        end else begin
          if (op == MODE_POP_FRONT) head_q = head_q + 4'd1;
          fill_q = fill_q - 5'd1;
          if (fill_q == 5'd0) head_q = 4'd0;
        end
      end
      MODE_REMOVE, MODE_FIND: begin
        // first match from the front
        for (k = 0; k < int'(fill_q); k++) begin
          slot = head_q + 4'(k);
          if (pos == DEPTH && ring_q[slot] == v) pos = k;
        end
        if (pos == DEPTH) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.found = 1'b1;
          if (op == MODE_REMOVE) begin
            // close the gap: later entries move up one place
            for (k = pos; k + 1 < int'(fill_q); k++) begin
              slot         = head_q + 4'(k);
              next_slot    = head_q + 4'(k + 1);
              ring_q[slot] = ring_q[next_slot];
            end
            fill_q = fill_q - 5'd1;
            if (fill_q == 5'd0) head_q = 4'd0;
          end
        end
      end
      MODE_CLEAR: begin
        fill_q = 5'd0;
        head_q = 4'd0;
      end
      default: begin
      end
    endcase
    r.count = fill_q;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: at each rising edge first retire a result (it belongs to a word
  // taken at an earlier edge), then log the word taken at this edge.
  // ---------------------------------------------------------------------------
  result_t want;
  result_t pred;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing pending: status %0d found %0d count %0d",
                 status_o, found_o, entry_count_o);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            err_count++;
          end
          if (found_o !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found_o);
            err_count++;
          end
          if (entry_count_o !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, entry_count_o);
            err_count++;
          end
        end
      end
      if (start_i && !busy_o) begin
        pred = deque_apply(mode_i, value_i);
        // typed rows override the shadow model, which still tracks state
        pending_results.push_back(row_has_exp ? row_exp : pred);
      end
    end
  end

  // hard stop
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_CAP) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: called at a falling edge, returns at the falling edge after the
  // word was taken with start_i still high, so back-to-back words need no
  // second assignment to start_i in one step.
  // ---------------------------------------------------------------------------
  task automatic send_word(logic [2:0] op, logic [31:0] v, logic has, result_t e);
    while (!quiet && $urandom_range(0, 99) < 15) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i     <= 1'b1;
    mode_i      <= op;
    value_i     <= v;
    row_has_exp <= has;
    row_exp     <= e;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic add_row(logic [2:0] op, logic [31:0] v, logic has,
                         logic [1:0] st, logic fd, logic [4:0] cnt);
    stim_row_t row;
    row.mode       = op;
    row.value      = v;
    row.has_exp    = has;
    row.exp.status = st;
    row.exp.found  = fd;
    row.exp.count  = cnt;
    dir_rows.push_back(row);
  endtask

  // cumulative mode weights (push front .. clear, rest is spare) per phase:
  // filling, draining, search-heavy
  int mix [3][7] = '{'{35, 70, 78, 84, 91, 98, 99},
                     '{15, 30, 55, 75, 85, 95, 97},
                     '{22, 44, 50, 56, 76, 96, 98}};
  // small pool so that finds/removes hit and duplicates pile up
  logic [31:0] val_pool [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                                32'h7FFF_FFFF, 32'h0000_0005, 32'h5A5A_5A5A};

  initial begin
    int          n;
    int          j;
    int          phase;
    int          r;
    logic [2:0]  op;
    logic [31:0] v;
    stim_row_t   row;

    rst_ni      = 1'b0;
    start_i     = 1'b0;
    mode_i      = MODE_PUSH_FRONT;
    value_i     = '0;
    row_has_exp = 1'b0;
    row_exp     = '0;
    quiet       = 1'b0;
    err_count   = 0;
    cycle_cnt   = 0;
    head_q      = '0;
    fill_q      = '0;
    for (j = 0; j < DEPTH; j++) ring_q[j] = '0;

    // -- directed table --
    // empty store after reset
    add_row(MODE_POP_FRONT, 32'h0,         1, STATUS_EMPTY, 0, 0);
    add_row(MODE_POP_BACK,  32'h0,         1, STATUS_EMPTY, 0, 0);
    add_row(MODE_FIND,      32'h0,         1, STATUS_EMPTY, 0, 0);
    add_row(MODE_REMOVE,    32'hFFFF_FFFF, 1, STATUS_EMPTY, 0, 0);
    // value extremes at both ends
    add_row(MODE_PUSH_BACK,  32'h7FFF_FFFF, 1, STATUS_OK, 0, 1);
    add_row(MODE_PUSH_FRONT, 32'h8000_0000, 1, STATUS_OK, 0, 2);
    // fill to capacity, front and back alternating, front wraps the ring
    for (j = 0; j < DEPTH - 2; j++) begin
      add_row(j[0] ? MODE_PUSH_BACK : MODE_PUSH_FRONT,
              (j % 3 == 0) ? 32'h5 : {j[7:0], ~j[7:0], j[7:0], ~j[7:0]},
              1, STATUS_OK, 0, 5'(j + 3));
    end
    // push into a full store is dropped
    add_row(MODE_PUSH_BACK,  32'h1,         1, STATUS_FULL, 0, 16);
    add_row(MODE_PUSH_FRONT, 32'h2,         1, STATUS_FULL, 0, 16);
    add_row(MODE_FIND,       32'h8000_0000, 1, STATUS_OK,   1, 16);
    // remaining rows but the final clear checked against the shadow model
    add_row(MODE_REMOVE,    32'h5,         0, STATUS_OK, 0, 0);  // duplicate, first copy at the front
    add_row(MODE_FIND,      32'h5,         0, STATUS_OK, 0, 0);
    add_row(MODE_REMOVE,    32'h1234_5678, 0, STATUS_OK, 0, 0);  // miss
    add_row(MODE_SPARE,     32'hFFFF_FFFF, 0, STATUS_OK, 0, 0);
    add_row(MODE_POP_FRONT, 32'h0,         0, STATUS_OK, 0, 0);
    add_row(MODE_POP_BACK,  32'h0,         0, STATUS_OK, 0, 0);
    add_row(MODE_CLEAR,     32'h0,         1, STATUS_OK, 0, 0);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_word(row.mode, row.value, row.has_exp, row.exp);
    end

    // -- random part --
    phase = 0;
    for (n = 0; n < RAND_WORDS; n++) begin
      if (n % 64 == 0) phase = $urandom_range(0, 2);
      quiet = (n >= 400 && n < 700);
      r  = $urandom_range(0, 99);
      op = MODE_SPARE;
      for (j = 6; j >= 0; j--) begin
        if (r < mix[phase][j]) op = 3'(j);
      end
      v = ($urandom_range(0, 3) == 0) ? 32'($urandom) : val_pool[$urandom_range(0, 5)];
      send_word(op, v, 1'b0, '0);
    end

    start_i <= 1'b0;
    quiet   = 1'b0;

    // drain, then watch a while for stray results
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/deq_pkg.sv
hw/rtl/deq_ring_add.sv
hw/rtl/deq_ram.sv
hw/rtl/bounded_deque_with_search_unit.sv
test/tb_bounded_deque_with_search_unit.sv
